@@ sv/tbse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbse_pkg
// Shared widths, types and codes of the two-branch subcarrier equalizer.
// ----------------------------------------------------------------------------
package tbse_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int MAX_SUBCARRIERS = 1024;
    localparam int IDX_W           = $clog2(MAX_SUBCARRIERS);
    localparam int LEN_W           = 11;
    localparam int EQ_W            = 24;
    localparam int EST_W           = 2 * SAMPLE_WIDTH;
    localparam int PROD_W          = 2 * SAMPLE_WIDTH;
    localparam int NUM_W           = 2 * SAMPLE_WIDTH + 2;
    localparam int DEN_W           = SAMPLE_WIDTH + 1;
    localparam int MAG_W           = 2 * SAMPLE_WIDTH + 2;
    localparam int P_W             = NUM_W + DEN_W;
    localparam int DCNT_W          = $clog2(P_W + 1);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_SUBCARRIERS);

    localparam logic [P_W-1:0] Q_HI_MAG = P_W'((64'd1 << (EQ_W - 1)) - 64'd1);
    localparam logic [P_W-1:0] Q_LO_MAG = P_W'(64'd1 << (EQ_W - 1));

    typedef logic signed [SAMPLE_WIDTH-1:0] t_smp;

    typedef struct packed {
        t_smp y0_re;
        t_smp y0_im;
        t_smp y1_re;
        t_smp y1_im;
        t_smp h0_re;
        t_smp h0_im;
        t_smp h1_re;
        t_smp h1_im;
        logic last;
    } t_item;

    typedef struct packed {
        logic push;
        logic full;
    } t_qctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_MUL2,
        ST_SUM2,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

@@ sv/tbse_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbse_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tbse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ sv/tbse_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbse_front
// Accepts requests, tracks the subcarrier index, updates/reads the estimate
// stores and hands complete items to the queue.
// ----------------------------------------------------------------------------
module tbse_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tbse_pkg::LEN_W-1:0]  i_len,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_frame_start,
    input  wire tbse_pkg::t_smp              i_y0_re,
    input  wire tbse_pkg::t_smp              i_y0_im,
    input  wire tbse_pkg::t_smp              i_y1_re,
    input  wire tbse_pkg::t_smp              i_y1_im,
    input  wire tbse_pkg::t_smp              i_h0_re,
    input  wire tbse_pkg::t_smp              i_h0_im,
    input  wire tbse_pkg::t_smp              i_h1_re,
    input  wire tbse_pkg::t_smp              i_h1_im,
    input  wire logic                        i_q_full,
    output tbse_pkg::t_qctl                  o_qctl,
    output tbse_pkg::t_item                  o_item
);
    localparam int IW = tbse_pkg::IDX_W;
    localparam int SW = tbse_pkg::SAMPLE_WIDTH;
    localparam int LW = tbse_pkg::LEN_W;

    logic          r_clr, n_clr;
    logic [IW-1:0] r_clr_addr, n_clr_addr;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_hold, n_hold;
    logic          r_fs;
    tbse_pkg::t_item r_item;

    logic                        accept, push, last;
    logic [LW-1:0]               len_c;
    logic                        we;
    logic [IW-1:0]               waddr;
    logic [tbse_pkg::EST_W-1:0]  wd0, wd1, rd0, rd1;

    always_comb begin
        if (i_len < tbse_pkg::LEN_MIN) begin
            len_c = tbse_pkg::LEN_MIN;
        end else if (i_len > tbse_pkg::LEN_MAX) begin
            len_c = tbse_pkg::LEN_MAX;
        end else begin
            len_c = i_len;
        end
    end

    assign last    = ({1'b0, r_idx} + LW'(1)) >= len_c;
    assign push    = r_hold && !i_q_full;
    assign o_stall = r_clr || (r_hold && i_q_full);
    assign accept  = i_valid && !o_stall;

    // Estimates arrive with the request on a frame start; bypass the store.
    always_comb begin
        o_item = r_item;
        if (!r_fs) begin
            o_item.h0_re = rd0[2*SW-1:SW];
            o_item.h0_im = rd0[SW-1:0];
            o_item.h1_re = rd1[2*SW-1:SW];
            o_item.h1_im = rd1[SW-1:0];
        end
        o_qctl.push = push;
        o_qctl.full = i_q_full;
    end

    always_comb begin
        n_clr      = r_clr;
        n_clr_addr = r_clr_addr;
        n_idx      = r_idx;
        n_hold     = r_hold;
        we         = 1'b0;
        waddr      = r_idx;
        wd0        = {i_h0_re, i_h0_im};
        wd1        = {i_h1_re, i_h1_im};
        if (r_clr) begin
            we         = 1'b1;
            waddr      = r_clr_addr;
            wd0        = '0;
            wd1        = '0;
            n_clr_addr = r_clr_addr + IW'(1);
            if (r_clr_addr == IW'(tbse_pkg::MAX_SUBCARRIERS - 1)) begin
                n_clr = 1'b0;
            end
        end else if (accept) begin
            we    = i_frame_start;
            n_idx = last ? '0 : r_idx + IW'(1);
        end
        if (push) begin
            n_hold = 1'b0;
        end
        if (accept) begin
            n_hold = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_idx      <= '0;
            r_hold     <= 1'b0;
        end else begin
            r_clr      <= n_clr;
            r_clr_addr <= n_clr_addr;
            r_idx      <= n_idx;
            r_hold     <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fs         <= i_frame_start;
            r_item.y0_re <= i_y0_re;
            r_item.y0_im <= i_y0_im;
            r_item.y1_re <= i_y1_re;
            r_item.y1_im <= i_y1_im;
            r_item.h0_re <= i_h0_re;
            r_item.h0_im <= i_h0_im;
            r_item.h1_re <= i_h1_re;
            r_item.h1_im <= i_h1_im;
            r_item.last  <= last;
        end
    end

    tbse_ram #(.WIDTH(tbse_pkg::EST_W), .DEPTH(tbse_pkg::MAX_SUBCARRIERS)) u_est0 (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wd0),
        .i_re   (accept),
        .i_raddr(r_idx),
        .o_rdata(rd0)
    );

    tbse_ram #(.WIDTH(tbse_pkg::EST_W), .DEPTH(tbse_pkg::MAX_SUBCARRIERS)) u_est1 (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wd1),
        .i_re   (accept),
        .i_raddr(r_idx),
        .o_rdata(rd1)
    );
endmodule
`default_nettype wire

@@ sv/tbse_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbse_queue
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
module tbse_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tbse_pkg::t_qctl i_qctl,
    input  wire tbse_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output tbse_pkg::t_item      o_item
);
    tbse_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_qctl.push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_qctl.push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_qctl.push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

@@ sv/tbse_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbse_back
// Combining arithmetic: products, numerator and denominator, two
// bit-serial dividers and saturation into the output register.
// ----------------------------------------------------------------------------
module tbse_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_q_empty,
    input  wire tbse_pkg::t_item                    i_item,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [tbse_pkg::EQ_W-1:0]        o_eq_re,
    output logic signed [tbse_pkg::EQ_W-1:0]        o_eq_im,
    output logic                                    o_last_subcarrier,
    output logic                                    o_saturated
);
    localparam int PW = tbse_pkg::PROD_W;
    localparam int NW = tbse_pkg::NUM_W;
    localparam int DW = tbse_pkg::DEN_W;
    localparam int MW = tbse_pkg::MAG_W;
    localparam int QW = tbse_pkg::P_W;
    localparam int EW = tbse_pkg::EQ_W;
    localparam int CW = tbse_pkg::DCNT_W;

    tbse_pkg::t_state r_st, n_st;
    tbse_pkg::t_item  r_it;
    logic signed [PW-1:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic signed [DW-1:0] r_dr, r_di;
    logic signed [NW-1:0] r_nr, r_ni;
    logic signed [QW-1:0] r_m1, r_m2, r_m3, r_m4;
    logic [MW-1:0]        r_mg1, r_mg2, r_mag;
    logic [QW-1:0]        r_dv_re, r_dv_im, r_q_re, r_q_im;
    logic [MW:0]          r_rm_re, r_rm_im;
    logic                 r_neg_re, r_neg_im;
    logic [CW-1:0]        r_cnt;
    logic                 r_ov, n_ov;

    logic signed [QW-1:0] p_re, p_im;
    logic [MW:0]          t_re, t_im;
    logic                 ge_re, ge_im, out_free;
    logic signed [EW-1:0] s_re, s_im;
    logic                 s_sat;

    assign out_free = !r_ov || !i_stall;
    assign p_re     = r_m1 + r_m2;
    assign p_im     = r_m3 - r_m4;
    assign t_re     = {r_rm_re[MW-1:0], r_dv_re[QW-1]};
    assign t_im     = {r_rm_im[MW-1:0], r_dv_im[QW-1]};
    assign ge_re    = t_re >= {1'b0, r_mag};
    assign ge_im    = t_im >= {1'b0, r_mag};

    // Truncating quotient, clipped to the output range.
    function automatic logic [EW:0] sat_q(logic [QW-1:0] qm, logic neg);
        logic [EW:0] res;
        res = '0;
        if (neg) begin
            if (qm > tbse_pkg::Q_LO_MAG) begin
                res = {1'b1, 1'b1, {(EW-1){1'b0}}};
            end else begin
                res = {1'b0, EW'(-qm)};
            end
        end else begin
            if (qm > tbse_pkg::Q_HI_MAG) begin
                res = {1'b1, 1'b0, {(EW-1){1'b1}}};
            end else begin
                res = {1'b0, EW'(qm)};
            end
        end
        return res;
    endfunction

    function automatic logic signed [EW-1:0] zero_den(logic signed [NW-1:0] n);
        logic signed [EW-1:0] res;
        res = '0;
        if (n > 0) begin
            res = {1'b0, {(EW-1){1'b1}}};
        end else if (n < 0) begin
            res = {1'b1, {(EW-1){1'b0}}};
        end
        return res;
    endfunction

    always_comb begin
        logic [EW:0] qr, qi;
        qr = sat_q(r_q_re, r_neg_re);
        qi = sat_q(r_q_im, r_neg_im);
        if (r_mag == '0) begin
            s_re  = zero_den(r_nr);
            s_im  = zero_den(r_ni);
            s_sat = 1'b1;
        end else begin
            s_re  = qr[EW-1:0];
            s_im  = qi[EW-1:0];
            s_sat = qr[EW] || qi[EW];
        end
    end

    always_comb begin
        n_st  = r_st;
        n_ov  = r_ov;
        o_pop = 1'b0;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_st)
            tbse_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_st  = tbse_pkg::ST_MUL;
                end
            end
            tbse_pkg::ST_MUL:  n_st = tbse_pkg::ST_SUM;
            tbse_pkg::ST_SUM:  n_st = tbse_pkg::ST_MUL2;
            tbse_pkg::ST_MUL2: n_st = tbse_pkg::ST_SUM2;
            tbse_pkg::ST_SUM2: n_st = tbse_pkg::ST_DIV;
            tbse_pkg::ST_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_st = tbse_pkg::ST_DONE;
                end
            end
            tbse_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_st = tbse_pkg::ST_IDLE;
                end
            end
            default: n_st = tbse_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tbse_pkg::ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_item;
        end
        case (r_st)
            tbse_pkg::ST_MUL: begin
                r_a  <= PW'(r_it.y0_re) * PW'(r_it.h0_re);
                r_b  <= PW'(r_it.y0_im) * PW'(r_it.h0_im);
                r_c  <= PW'(r_it.y1_re) * PW'(r_it.h1_re);
                r_d  <= PW'(r_it.y1_im) * PW'(r_it.h1_im);
                r_e  <= PW'(r_it.y0_re) * PW'(r_it.h0_im);
                r_f  <= PW'(r_it.y0_im) * PW'(r_it.h0_re);
                r_g  <= PW'(r_it.y1_re) * PW'(r_it.h1_im);
                r_h  <= PW'(r_it.y1_im) * PW'(r_it.h1_re);
                r_dr <= DW'(r_it.h0_re) + DW'(r_it.h1_re);
                r_di <= DW'(r_it.h0_im) + DW'(r_it.h1_im);
            end
            tbse_pkg::ST_SUM: begin
                r_nr <= NW'(r_a) - NW'(r_b) + NW'(r_c) - NW'(r_d);
                r_ni <= NW'(r_e) + NW'(r_f) + NW'(r_g) + NW'(r_h);
            end
            tbse_pkg::ST_MUL2: begin
                r_m1  <= QW'(r_nr) * QW'(r_dr);
                r_m2  <= QW'(r_ni) * QW'(r_di);
                r_m3  <= QW'(r_ni) * QW'(r_dr);
                r_m4  <= QW'(r_nr) * QW'(r_di);
                r_mg1 <= MW'(MW'(r_dr) * MW'(r_dr));
                r_mg2 <= MW'(MW'(r_di) * MW'(r_di));
            end
            tbse_pkg::ST_SUM2: begin
                r_mag    <= r_mg1 + r_mg2;
                r_neg_re <= p_re[QW-1];
                r_neg_im <= p_im[QW-1];
                r_dv_re  <= p_re[QW-1] ? QW'(-p_re) : QW'(p_re);
                r_dv_im  <= p_im[QW-1] ? QW'(-p_im) : QW'(p_im);
                r_rm_re  <= '0;
                r_rm_im  <= '0;
                r_q_re   <= '0;
                r_q_im   <= '0;
                r_cnt    <= CW'(QW);
            end
            tbse_pkg::ST_DIV: begin
                r_rm_re <= ge_re ? t_re - {1'b0, r_mag} : t_re;
                r_rm_im <= ge_im ? t_im - {1'b0, r_mag} : t_im;
                r_q_re  <= {r_q_re[QW-2:0], ge_re};
                r_q_im  <= {r_q_im[QW-2:0], ge_im};
                r_dv_re <= {r_dv_re[QW-2:0], 1'b0};
                r_dv_im <= {r_dv_im[QW-2:0], 1'b0};
                r_cnt   <= r_cnt - CW'(1);
            end
            tbse_pkg::ST_DONE: begin
                if (out_free) begin
                    o_eq_re           <= s_re;
                    o_eq_im           <= s_im;
                    o_saturated       <= s_sat;
                    o_last_subcarrier <= r_it.last;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

@@ sv/two_branch_subcarrier_equalizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// two_branch_subcarrier_equalizer
// 1x2 per-subcarrier OFDM equalizer: (y0*h0 + y1*h1) / (h0 + h1).
// ----------------------------------------------------------------------------
// Each request carries one subcarrier of two receive branches. The front
// keeps the subcarrier counter and two 1024-entry estimate stores; on a
// frame-start request the request's estimates overwrite the store entry and
// are used directly. The back computes the combined sample in complex fixed
// point (Q8.15 out, saturating, with a flag for a zero denominator or a
// clipped quotient). The back finishes an item before popping the next: the
// queue pop, four multiply/sum steps, two bit-serial dividers (51 quotient
// bits, one per cycle) and the hand-off to the output register, which waits
// while the output stalls; the front and a two-entry queue accept further
// requests meanwhile. After reset the front clears both stores, stalling
// input; configuration writes are taken at any time. active_subcarriers
// lives at byte address 0; values below 2 act as 2, above 1024 as 1024.
// ----------------------------------------------------------------------------
module two_branch_subcarrier_equalizer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // request in
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_frame_start,
    input  wire tbse_pkg::t_smp                i_y0_re,
    input  wire tbse_pkg::t_smp                i_y0_im,
    input  wire tbse_pkg::t_smp                i_y1_re,
    input  wire tbse_pkg::t_smp                i_y1_im,
    input  wire tbse_pkg::t_smp                i_h0_re,
    input  wire tbse_pkg::t_smp                i_h0_im,
    input  wire tbse_pkg::t_smp                i_h1_re,
    input  wire tbse_pkg::t_smp                i_h1_im,
    // result out
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [tbse_pkg::EQ_W-1:0]   o_eq_re,
    output logic signed [tbse_pkg::EQ_W-1:0]   o_eq_im,
    output logic                               o_last_subcarrier,
    output logic                               o_saturated
);
    logic [tbse_pkg::LEN_W-1:0] r_len;
    tbse_pkg::t_qctl            qctl;
    tbse_pkg::t_item            f_item, q_item;
    logic                       q_full, q_empty, pop;

    // Register index is paddr[2]; only index 0 exists.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - tbse_pkg::LEN_W){1'b0}}, r_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= tbse_pkg::LEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_len <= pwdata[tbse_pkg::LEN_W-1:0];
        end
    end

    tbse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_len        (r_len),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_frame_start(i_frame_start),
        .i_y0_re      (i_y0_re),
        .i_y0_im      (i_y0_im),
        .i_y1_re      (i_y1_re),
        .i_y1_im      (i_y1_im),
        .i_h0_re      (i_h0_re),
        .i_h0_im      (i_h0_im),
        .i_h1_re      (i_h1_re),
        .i_h1_im      (i_h1_im),
        .i_q_full     (q_full),
        .o_qctl       (qctl),
        .o_item       (f_item)
    );

    tbse_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_qctl (qctl),
        .i_item (f_item),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_item (q_item)
    );

    tbse_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_item           (q_item),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_eq_re          (o_eq_re),
        .o_eq_im          (o_eq_im),
        .o_last_subcarrier(o_last_subcarrier),
        .o_saturated      (o_saturated)
    );
endmodule
`default_nettype wire
